@@ src/spf_pkg.sv @@
// Package for the shade pair block: types and constants shared by the
// front end, the divider pipeline and the top level. No dependencies.
package spf_pkg;

   // sizes of the fixed-point datapath
   localparam int unsigned CH_W      = 8;   // one color channel
   localparam int unsigned PIX_W     = 24;  // packed RGB
   localparam int unsigned NUM_W     = 17;  // (255+M)*X fits in 17 bits
   localparam int unsigned DEN_W     = 9;   // 2*M fits in 9 bits
   localparam int unsigned DIV_STEPS = 8;   // one quotient bit per stage
   localparam int unsigned LANES     = 4;

   // divider lanes
   localparam int unsigned LANE_BRIGHT_P   = 0;
   localparam int unsigned LANE_BRIGHT_MID = 1;
   localparam int unsigned LANE_DARK_P     = 2;
   localparam int unsigned LANE_DARK_MID   = 3;

   localparam logic [CH_W-1:0]  LEVEL_MAX = 8'hFF;
   localparam logic [PIX_W-1:0] WHITE     = 24'hFFFFFF;

   // hexcone sextant of the hue
   typedef enum logic [2:0] {
      SEXT_0 = 3'd0,
      SEXT_1 = 3'd1,
      SEXT_2 = 3'd2,
      SEXT_3 = 3'd3,
      SEXT_4 = 3'd4,
      SEXT_5 = 3'd5
   } spf_sext_type;

   // data that rides alongside the divider lanes
   typedef struct packed {
      spf_sext_type       sext;
      logic               gray;
      logic [CH_W-1:0]    v_dark;
      logic [PIX_W-1:0]   base;
   } spf_side_type;

endpackage

@@ src/spf_front.sv @@
// Front end of the shade pair block: input register, hexcone hue analysis
// and the numerator products for the dividers. Depends on spf_pkg.
module spf_front (
   input  logic                                       clock,
   input  logic                                       reset,
   input  logic                                       enable,
   input  logic                                       in_valid,
   input  logic [spf_pkg::PIX_W-1:0]                  in_pixel,
   output logic                                       out_valid,
   output spf_pkg::spf_side_type                      out_side,
   output logic [spf_pkg::LANES-1:0][spf_pkg::NUM_W-1:0] out_num,
   output logic [spf_pkg::LANES-1:0][spf_pkg::DEN_W-1:0] out_den
);

   // stage 1: captured pixel
   logic                        s1_valid_ff;
   logic [spf_pkg::PIX_W-1:0]   s1_pixel_ff;

   // stage 2: hue analysis
   logic                        s2_valid_ff;
   spf_pkg::spf_side_type       s2_side_ff, s2_side_in;
   logic [spf_pkg::CH_W-1:0]    s2_max_ff, s2_max_in;
   logic [spf_pkg::CH_W-1:0]    s2_min_ff, s2_min_in;
   logic [spf_pkg::CH_W-1:0]    s2_mid_ff, s2_mid_in;

   // stage 3: numerators and divisors
   logic                        s3_valid_ff;
   spf_pkg::spf_side_type       s3_side_ff;
   logic [spf_pkg::LANES-1:0][spf_pkg::NUM_W-1:0] s3_num_ff, s3_num_in;
   logic [spf_pkg::LANES-1:0][spf_pkg::DEN_W-1:0] s3_den_ff, s3_den_in;

   logic [spf_pkg::CH_W-1:0]    r, g, b, mx, mn, dd, fn;
   logic                        r_max, g_max;
   spf_pkg::spf_sext_type       sext;
   logic [spf_pkg::DEN_W-1:0]   sum_m;

   // capture the incoming transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (enable) begin
         s1_valid_ff <= in_valid;
      end
      if (enable) begin
         s1_pixel_ff <= in_pixel;
      end
   end

   // find max, min, sextant and fractional offset
   always_comb begin
      r = s1_pixel_ff[23:16];
      g = s1_pixel_ff[15:8];
      b = s1_pixel_ff[7:0];
      r_max = (r >= g) && (r >= b);
      g_max = !r_max && (g >= b);
      if (r_max) begin
         mx = r;
      end else if (g_max) begin
         mx = g;
      end else begin
         mx = b;
      end
      mn = r;
      if (g < mn) mn = g;
      if (b < mn) mn = b;
      dd = mx - mn;
      if (r_max) begin
         if (g >= b) begin
            if ((g - b) == dd) begin
               sext = spf_pkg::SEXT_1;
               fn   = '0;
            end else begin
               sext = spf_pkg::SEXT_0;
               fn   = g - b;
            end
         end else begin
            sext = spf_pkg::SEXT_5;
            fn   = g - b + dd;
         end
      end else if (g_max) begin
         if (b >= r) begin
            if ((b - r) == dd) begin
               sext = spf_pkg::SEXT_3;
               fn   = '0;
            end else begin
               sext = spf_pkg::SEXT_2;
               fn   = b - r;
            end
         end else begin
            sext = spf_pkg::SEXT_1;
            fn   = b - r + dd;
         end
      end else begin
         if (r >= g) begin
            sext = spf_pkg::SEXT_4;
            fn   = r - g;
         end else begin
            sext = spf_pkg::SEXT_3;
            fn   = r - g + dd;
         end
      end
      // odd sextants fall (q), even ones rise (t)
      s2_mid_in = sext[0] ? (mx - fn) : (mn + fn);
      s2_max_in = mx;
      s2_min_in = mn;
      sum_m = {1'b0, mx} + {1'b0, spf_pkg::LEVEL_MAX};
      s2_side_in.sext   = sext;
      s2_side_in.gray   = (dd == '0);
      s2_side_in.v_dark = sum_m[8:1];
      s2_side_in.base   = s1_pixel_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (enable) begin
         s2_valid_ff <= s1_valid_ff;
      end
      if (enable) begin
         s2_side_ff <= s2_side_in;
         s2_max_ff  <= s2_max_in;
         s2_min_ff  <= s2_min_in;
         s2_mid_ff  <= s2_mid_in;
      end
   end

   // form 255*X and (255+M)*X, divisors M and 2M
   always_comb begin
      logic [spf_pkg::NUM_W-1:0] scale_dark;
      scale_dark = {9'd0, s2_max_ff} + {9'd0, spf_pkg::LEVEL_MAX};
      s3_num_in[spf_pkg::LANE_BRIGHT_P] =
         {1'b0, s2_min_ff, 8'd0} - {9'd0, s2_min_ff};
      s3_num_in[spf_pkg::LANE_BRIGHT_MID] =
         {1'b0, s2_mid_ff, 8'd0} - {9'd0, s2_mid_ff};
      s3_num_in[spf_pkg::LANE_DARK_P]   = scale_dark * {9'd0, s2_min_ff};
      s3_num_in[spf_pkg::LANE_DARK_MID] = scale_dark * {9'd0, s2_mid_ff};
      s3_den_in[spf_pkg::LANE_BRIGHT_P]   = {1'b0, s2_max_ff};
      s3_den_in[spf_pkg::LANE_BRIGHT_MID] = {1'b0, s2_max_ff};
      s3_den_in[spf_pkg::LANE_DARK_P]     = {s2_max_ff, 1'b0};
      s3_den_in[spf_pkg::LANE_DARK_MID]   = {s2_max_ff, 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (enable) begin
         s3_valid_ff <= s2_valid_ff;
      end
      if (enable) begin
         s3_side_ff <= s2_side_ff;
         s3_num_ff  <= s3_num_in;
         s3_den_ff  <= s3_den_in;
      end
   end

   assign out_valid = s3_valid_ff;
   assign out_side  = s3_side_ff;
   assign out_num   = s3_num_ff;
   assign out_den   = s3_den_ff;

endmodule

@@ src/spf_div_pipe.sv @@
// Pipelined restoring divider, four lanes, one quotient bit per stage.
// Carries the side data alongside. Depends on spf_pkg.
module spf_div_pipe (
   input  logic                                          clock,
   input  logic                                          reset,
   input  logic                                          enable,
   input  logic                                          in_valid,
   input  spf_pkg::spf_side_type                         in_side,
   input  logic [spf_pkg::LANES-1:0][spf_pkg::NUM_W-1:0] in_num,
   input  logic [spf_pkg::LANES-1:0][spf_pkg::DEN_W-1:0] in_den,
   output logic                                          out_valid,
   output spf_pkg::spf_side_type                         out_side,
   output logic [spf_pkg::LANES-1:0][spf_pkg::CH_W-1:0]  out_quo
);

   localparam int unsigned STEPS = spf_pkg::DIV_STEPS;

   // stage 0 is the input, stages 1..STEPS are registers
   logic                                          valid_s [0:STEPS];
   spf_pkg::spf_side_type                         side_s  [0:STEPS];
   logic [spf_pkg::LANES-1:0][spf_pkg::NUM_W-1:0] rem_s   [0:STEPS];
   logic [spf_pkg::LANES-1:0][spf_pkg::DEN_W-1:0] den_s   [0:STEPS];
   logic [spf_pkg::LANES-1:0][spf_pkg::CH_W-1:0]  quo_s   [0:STEPS];

   assign valid_s[0] = in_valid;
   assign side_s[0]  = in_side;
   assign rem_s[0]   = in_num;
   assign den_s[0]   = in_den;
   assign quo_s[0]   = '0;

   for (genvar k = 0; k < STEPS; k++) begin : g_step
      localparam int unsigned SH = STEPS - 1 - k;
      logic                                          valid_ff;
      spf_pkg::spf_side_type                         side_ff;
      logic [spf_pkg::LANES-1:0][spf_pkg::NUM_W-1:0] rem_ff, rem_in;
      logic [spf_pkg::LANES-1:0][spf_pkg::DEN_W-1:0] den_ff;
      logic [spf_pkg::LANES-1:0][spf_pkg::CH_W-1:0]  quo_ff, quo_in;

      // trial subtract of the shifted divisor, one lane each
      always_comb begin
         for (int ln = 0; ln < spf_pkg::LANES; ln++) begin
            logic [spf_pkg::NUM_W-1:0] trial;
            logic                      fits;
            trial = spf_pkg::NUM_W'(den_s[k][ln]) << SH;
            fits  = rem_s[k][ln] >= trial;
            rem_in[ln] = fits ? (rem_s[k][ln] - trial) : rem_s[k][ln];
            quo_in[ln] = {quo_s[k][ln][spf_pkg::CH_W-2:0], fits};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff <= 1'b0;
         end else if (enable) begin
            valid_ff <= valid_s[k];
         end
         if (enable) begin
            side_ff <= side_s[k];
            rem_ff  <= rem_in;
            den_ff  <= den_s[k];
            quo_ff  <= quo_in;
         end
      end

      assign valid_s[k+1] = valid_ff;
      assign side_s[k+1]  = side_ff;
      assign rem_s[k+1]   = rem_ff;
      assign den_s[k+1]   = den_ff;
      assign quo_s[k+1]   = quo_ff;
   end

   assign out_valid = valid_s[STEPS];
   assign out_side  = side_s[STEPS];
   assign out_quo   = quo_s[STEPS];

endmodule

@@ src/shade_pair_from_color.sv @@
// Shade pair block: takes one packed RGB color per transaction and returns
// the color, a dark shade at value (1+v)/2 and a bright shade at full value,
// both with the hue and saturation of the input. Fully pipelined: one
// transaction enters every clock while req_stall is low and passes the
// input register, hue stage, multiply stage, eight divider stages - one
// quotient bit each - and the output register. The whole pipe holds while
// a result waits under rsp_stall; req_stall is then high. No configuration.
// Depends on spf_pkg, spf_front and spf_div_pipe.
module shade_pair_from_color (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [spf_pkg::PIX_W-1:0]   req_pixel_in,
   output logic                        rsp_valid,
   input  logic                        rsp_stall,
   output logic [spf_pkg::PIX_W-1:0]   rsp_base_color,
   output logic [spf_pkg::PIX_W-1:0]   rsp_dark_shade,
   output logic [spf_pkg::PIX_W-1:0]   rsp_bright_shade
);

   logic                                          enable;
   logic                                          fr_valid;
   spf_pkg::spf_side_type                         fr_side;
   logic [spf_pkg::LANES-1:0][spf_pkg::NUM_W-1:0] fr_num;
   logic [spf_pkg::LANES-1:0][spf_pkg::DEN_W-1:0] fr_den;
   logic                                          dv_valid;
   spf_pkg::spf_side_type                         dv_side;
   logic [spf_pkg::LANES-1:0][spf_pkg::CH_W-1:0]  dv_quo;

   logic                        rsp_valid_ff;
   logic [spf_pkg::PIX_W-1:0]   base_ff, base_in;
   logic [spf_pkg::PIX_W-1:0]   dark_ff, dark_in;
   logic [spf_pkg::PIX_W-1:0]   bright_ff, bright_in;

   // advance everything unless a finished result is held
   assign enable    = !(rsp_valid_ff && rsp_stall);
   assign req_stall = !enable;

   spf_front u_front (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (req_valid),
      .in_pixel  (req_pixel_in),
      .out_valid (fr_valid),
      .out_side  (fr_side),
      .out_num   (fr_num),
      .out_den   (fr_den)
   );

   spf_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (fr_valid),
      .in_side   (fr_side),
      .in_num    (fr_num),
      .in_den    (fr_den),
      .out_valid (dv_valid),
      .out_side  (dv_side),
      .out_quo   (dv_quo)
   );

   // place v, p and the moving channel per sextant
   function automatic logic [spf_pkg::PIX_W-1:0] place(
      input spf_pkg::spf_sext_type s,
      input logic [spf_pkg::CH_W-1:0] v,
      input logic [spf_pkg::CH_W-1:0] p,
      input logic [spf_pkg::CH_W-1:0] x
   );
      logic [spf_pkg::PIX_W-1:0] res;
      unique case (s)
         spf_pkg::SEXT_0: res = {v, x, p};
         spf_pkg::SEXT_1: res = {x, v, p};
         spf_pkg::SEXT_2: res = {p, v, x};
         spf_pkg::SEXT_3: res = {p, x, v};
         spf_pkg::SEXT_4: res = {x, p, v};
         spf_pkg::SEXT_5: res = {v, p, x};
         default:         res = {v, p, x};
      endcase
      return res;
   endfunction

   // assemble the shades; gray has no hue
   always_comb begin
      base_in = dv_side.base;
      if (dv_side.gray) begin
         dark_in   = {dv_side.v_dark, dv_side.v_dark, dv_side.v_dark};
         bright_in = spf_pkg::WHITE;
      end else begin
         dark_in   = place(dv_side.sext, dv_side.v_dark,
                           dv_quo[spf_pkg::LANE_DARK_P],
                           dv_quo[spf_pkg::LANE_DARK_MID]);
         bright_in = place(dv_side.sext, spf_pkg::LEVEL_MAX,
                           dv_quo[spf_pkg::LANE_BRIGHT_P],
                           dv_quo[spf_pkg::LANE_BRIGHT_MID]);
      end
   end

   // output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (enable) begin
         rsp_valid_ff <= dv_valid;
      end
      if (enable) begin
         base_ff   <= base_in;
         dark_ff   <= dark_in;
         bright_ff <= bright_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_base_color   = base_ff;
   assign rsp_dark_shade   = dark_ff;
   assign rsp_bright_shade = bright_ff;

   // gray input gives a white bright shade
   a_gray_white: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_base_color[23:16] == rsp_base_color[15:8])
      && (rsp_base_color[15:8] == rsp_base_color[7:0])
      |-> rsp_bright_shade == spf_pkg::WHITE)
      else $error("gray color did not give a white bright shade");

   // every dark channel lies between the base and the bright channel
   a_order: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |->
      (rsp_dark_shade[23:16] >= rsp_base_color[23:16])
      && (rsp_dark_shade[15:8] >= rsp_base_color[15:8])
      && (rsp_dark_shade[7:0] >= rsp_base_color[7:0])
      && (rsp_bright_shade[23:16] >= rsp_dark_shade[23:16])
      && (rsp_bright_shade[15:8] >= rsp_dark_shade[15:8])
      && (rsp_bright_shade[7:0] >= rsp_dark_shade[7:0]))
      else $error("shade channels out of order");

   // the input side holds exactly when a result is held
   a_hold: assert property (@(posedge clock) disable iff (reset)
      req_stall == (rsp_valid && rsp_stall))
      else $error("input stall does not follow the output hold");

endmodule

@@ test/tb.sv @@
// Self-checking testbench for shade_pair_from_color: drives packed RGB colors
// with random idling and stalls and compares each result with a predictor.
// Depends on spf_pkg and the shade_pair_from_color RTL.
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [spf_pkg::PIX_W-1:0] base;
      logic [spf_pkg::PIX_W-1:0] dark;
      logic [spf_pkg::PIX_W-1:0] bright;
   } shade_set_type;

   // predicted shade sets in flight, oldest first
   class shade_scoreboard;
      shade_set_type pending[$];
      int            errors;

      // scale one channel term to an 8-bit level
      function logic [7:0] to_level(int unsigned x, int unsigned mx, bit dark);
         if (dark) return 8'(((255 + mx) * x) / (2 * mx));
         return 8'((255 * x) / mx);
      endfunction

      function logic [spf_pkg::PIX_W-1:0] rebuild_color(int unsigned sx,
                                                        int unsigned fn,
                                                        int unsigned mx,
                                                        int unsigned mn,
                                                        bit dark);
         logic [7:0] v, p, q, t;
         v = to_level(mx, mx, dark);
         p = to_level(mn, mx, dark);
         q = to_level(mx - fn, mx, dark);
         t = to_level(mn + fn, mx, dark);
         case (sx)
            spf_pkg::SEXT_0: return {v, t, p};
            spf_pkg::SEXT_1: return {q, v, p};
            spf_pkg::SEXT_2: return {p, v, t};
            spf_pkg::SEXT_3: return {p, q, v};
            spf_pkg::SEXT_4: return {t, p, v};
            default: return {v, p, q};
         endcase
      endfunction

      // note an accepted color and queue its expected shades
      function void note_color(logic [spf_pkg::PIX_W-1:0] px);
         shade_set_type s;
         int unsigned   r, g, b, mx, mn, d, hue_num;
         int            num;
         r = px[23:16]; g = px[15:8]; b = px[7:0];
         mx = r; mn = r;
         if (g > mx) mx = g;
         if (b > mx) mx = b;
         if (g < mn) mn = g;
         if (b < mn) mn = b;
         d = mx - mn;
         s.base = px;
         if (d == 0) begin
            s.dark   = {3{8'((255 + mx) / 2)}};
            s.bright = spf_pkg::WHITE;
         end else begin
            if (r == mx) begin
               num = int'(g) - int'(b);
               if (num < 0) num += 6 * int'(d);
            end else if (g == mx) begin
               num = 2 * int'(d) + int'(b) - int'(r);
            end else begin
               num = 4 * int'(d) + int'(r) - int'(g);
            end
            hue_num  = num;
            s.dark   = rebuild_color(hue_num / d, hue_num % d, mx, mn, 1'b1);
            s.bright = rebuild_color(hue_num / d, hue_num % d, mx, mn, 1'b0);
         end
         pending.push_back(s);
      endfunction

      // compare one result with the oldest expectation
      function void check_result(logic [spf_pkg::PIX_W-1:0] base,
                                 logic [spf_pkg::PIX_W-1:0] dark,
                                 logic [spf_pkg::PIX_W-1:0] bright);
         shade_set_type s;
         if (pending.size() == 0) begin
            $display("%0t: unexpected result base %h", $time, base);
            errors++;
            return;
         end
         s = pending.pop_front();
         if (base !== s.base) begin
            $display("%0t: base_color expected %h actual %h", $time, s.base, base);
            errors++;
         end
         if (dark !== s.dark) begin
            $display("%0t: dark_shade of %h expected %h actual %h",
                     $time, s.base, s.dark, dark);
            errors++;
         end
         if (bright !== s.bright) begin
            $display("%0t: bright_shade of %h expected %h actual %h",
                     $time, s.base, s.bright, bright);
            errors++;
         end
      endfunction
   endclass

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [spf_pkg::PIX_W-1:0] req_pixel_in = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic [spf_pkg::PIX_W-1:0] rsp_base_color, rsp_dark_shade, rsp_bright_shade;

   shade_scoreboard shades = new();
   bit              calm_phase = 1'b0;   // no idling in the last part
   bit              hold_rsp = 1'b0;     // long receiver hold-off
   int              cycle_count = 0;

   shade_pair_from_color uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // limit the run
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 200000) begin
         $display("shade_pair_from_color regression: fail");
         $finish;
      end
   end

   // check accepted results
   always @(posedge clock)
      if (!reset && rsp_valid && !rsp_stall)
         shades.check_result(rsp_base_color, rsp_dark_shade, rsp_bright_shade);

   // receiver stall in random bursts
   initial begin
      int n;
      @(posedge clock);
      forever begin
         if (hold_rsp) begin
            rsp_stall <= 1'b1;
            @(posedge clock);
         end else if (!calm_phase && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 9);
            rsp_stall <= 1'b1;
            repeat (n) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            @(posedge clock);
         end
      end
   end

   // offer one color and hold it until accepted
   task automatic send_color(logic [spf_pkg::PIX_W-1:0] px);
      int n;
      if (!calm_phase && $urandom_range(0, 4) == 0) begin
         n = $urandom_range(1, 9);
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_pixel_in <= px;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      shades.note_color(px);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (shades.pending.size() != 0) @(posedge clock);
   endtask

   function automatic logic [spf_pkg::PIX_W-1:0] random_color();
      logic [7:0] c[3];
      int         mode;
      mode = $urandom_range(0, 9);
      c[0] = 8'($urandom); c[1] = 8'($urandom); c[2] = 8'($urandom);
      case (mode)
         0: c[1] = c[0];                      // tie on two channels
         1: begin c[1] = c[0]; c[2] = c[0]; end // gray
         2: c[$urandom_range(0, 2)] = 8'hFF;
         3: c[$urandom_range(0, 2)] = 8'h00;
         4: begin c[0] = 8'($urandom_range(0, 3)); c[1] = 8'($urandom_range(0, 3));
                  c[2] = 8'($urandom_range(0, 3)); end
         default: ;
      endcase
      if (mode < 2 && $urandom_range(0, 1)) return {c[2], c[0], c[1]};
      return {c[0], c[1], c[2]};
   endfunction

   initial begin
      logic [spf_pkg::PIX_W-1:0] directed[$];
      directed = '{24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101, 24'hFF0000,
                   24'h00FF00, 24'h0000FF, 24'hFFFF00, 24'h00FFFF, 24'hFF00FF,
                   24'hFF8000, 24'h80FF00, 24'h00FF80, 24'h0080FF, 24'h8000FF,
                   24'hFF0080, 24'h010000, 24'h000001, 24'hFEFFFF, 24'h123456,
                   24'hAA55AA, 24'h55AA55, 24'h0F0F0E, 24'hFFFFFE};
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed[i]) send_color(directed[i]);
      drain_results();

      for (int i = 0; i < 1950; i++) begin
         if (i == 300) begin
            // hold the receiver long enough to fill the pipe
            hold_rsp = 1'b1;
            fork
               begin repeat (60) @(posedge clock); hold_rsp = 1'b0; end
            join_none
         end
         if (i == 700) drain_results();
         if (i == 1700) calm_phase = 1'b1;
         send_color(random_color());
      end
      req_valid <= 1'b0;
      drain_results();
      repeat (20) @(posedge clock);

      if (shades.errors == 0 && shades.pending.size() == 0)
         $display("shade_pair_from_color regression: pass");
      else
         $display("shade_pair_from_color regression: fail");
      $finish;
   end
endmodule
